/* hw/rtl/rtrp_pkg.sv */
// ----------------------------------------------------------------------------
// rtrp_pkg
// Shared constants and types for the radar text record parser.
// ----------------------------------------------------------------------------
package rtrp_pkg;

    localparam int WINDOW         = 8;
    localparam int LINE_MAX_CHARS = 63;
    localparam int QUEUE_DEPTH    = 2;   // power of two

    localparam int DIST_W  = 16;
    localparam int LC_W    = $clog2(LINE_MAX_CHARS + 1);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = DIST_W + $clog2(WINDOW);
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              present;
        logic [DIST_W-1:0] dist_cm;
    } t_rec;

endpackage

/* hw/rtl/rtrp_ram.sv */
// ----------------------------------------------------------------------------
// rtrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rtrp_front.sv */
// ----------------------------------------------------------------------------
// rtrp_front
// Byte-level line parser; pushes one record per valid line.
// ----------------------------------------------------------------------------
module rtrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output rtrp_pkg::t_rec o_rec
);

    localparam logic [3:0] PH_LEAD    = 4'd0;
    localparam logic [3:0] PH_O1      = 4'd1;
    localparam logic [3:0] PH_O2      = 4'd2;
    localparam logic [3:0] PH_OFF     = 4'd3;
    localparam logic [3:0] PH_LABEL   = 4'd4;
    localparam logic [3:0] PH_SEP     = 4'd5;
    localparam logic [3:0] PH_COLON   = 4'd6;
    localparam logic [3:0] PH_SIGN    = 4'd7;
    localparam logic [3:0] PH_DIGITS  = 4'd8;
    localparam logic [3:0] PH_TRAIL   = 4'd9;
    localparam logic [3:0] PH_FAIL    = 4'd10;
    localparam logic [3:0] PH_OFF_END = 4'd11;
    localparam logic [3:0] PH_NUM_END = 4'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_O  = 8'h4F;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_D  = 8'h64;

    localparam logic [16:0] NUM_OVER = 17'd65536;

    function automatic logic [7:0] label_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h64;  // d
            3'd1:    c = 8'h69;  // i
            3'd2:    c = 8'h73;  // s
            3'd3:    c = 8'h74;  // t
            3'd4:    c = 8'h61;  // a
            3'd5:    c = 8'h6E;  // n
            3'd6:    c = 8'h63;  // c
            default: c = 8'h65;  // e
        endcase
        return c;
    endfunction

    logic [3:0]                  r_phase, n_phase;
    logic [rtrp_pkg::LC_W-1:0]   r_count, n_count;
    logic                        r_ovf, n_ovf;
    logic [16:0]                 r_value, n_value;
    logic                        r_big, n_big;
    logic                        r_neg, n_neg;

    logic        w_take;
    logic        w_term;
    logic        w_blank;
    logic        w_digit;
    logic [20:0] w_mac;

    assign o_ready = !i_q_full;
    assign w_take  = i_valid && o_ready;
    assign w_term  = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign w_blank = (i_rx_byte == CH_SPACE) || (i_rx_byte == CH_TAB);
    assign w_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign w_mac   = ({4'd0, r_value} << 3) + ({4'd0, r_value} << 1)
                   + {17'd0, i_rx_byte[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_value = r_value;
        n_big   = r_big;
        n_neg   = r_neg;
        o_push  = 1'b0;
        o_rec   = '0;

        if (w_take) begin
            if (w_term) begin
                if (!r_ovf && (r_count != '0)) begin
                    if ((r_phase == PH_OFF) || (r_phase == PH_OFF_END)) begin
                        o_push = 1'b1;
                    end else if (((r_phase == PH_DIGITS) || (r_phase == PH_TRAIL) ||
                                  (r_phase == PH_NUM_END)) && !r_big &&
                                 !(r_neg && (r_value != '0))) begin
                        o_push        = 1'b1;
                        o_rec.present = 1'b1;
                        o_rec.dist_cm = r_value[15:0];
                    end
                end
                n_phase = PH_LEAD;
                n_count = '0;
                n_ovf   = 1'b0;
                n_value = '0;
                n_big   = 1'b0;
                n_neg   = 1'b0;
            end else if (!r_ovf) begin
                if (r_count < rtrp_pkg::LC_W'(rtrp_pkg::LINE_MAX_CHARS)) begin
                    n_count = r_count + 1'b1;
                    case (r_phase)
                        PH_LEAD: begin
                            if (!w_blank) begin
                                if (i_rx_byte == CH_UP_O) begin
                                    n_phase = PH_O1;
                                end else if (i_rx_byte == CH_LO_D) begin
                                    n_value = 17'd1;
                                    n_phase = PH_LABEL;
                                end else begin
                                    n_phase = PH_FAIL;
                                end
                            end
                        end
                        PH_O1: begin
                            n_phase = (i_rx_byte == CH_UP_F) ? PH_O2 : PH_FAIL;
                        end
                        PH_O2: begin
                            n_phase = (i_rx_byte == CH_UP_F) ? PH_OFF : PH_FAIL;
                        end
                        PH_OFF: begin
                            n_phase = (i_rx_byte == CH_NUL) ? PH_OFF_END : PH_FAIL;
                        end
                        PH_LABEL: begin
                            if (i_rx_byte == label_char(r_value[2:0])) begin
                                if (r_value[2:0] == 3'd7) begin
                                    n_value = '0;
                                    n_phase = PH_SEP;
                                end else begin
                                    n_value = r_value + 1'b1;
                                end
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_SEP: begin
                            if (!w_blank) begin
                                n_phase = (i_rx_byte == CH_COLON) ? PH_COLON : PH_FAIL;
                            end
                        end
                        PH_COLON: begin
                            if (!(w_blank || (i_rx_byte == CH_VT) || (i_rx_byte == CH_FF))) begin
                                if (i_rx_byte == CH_PLUS) begin
                                    n_phase = PH_SIGN;
                                end else if (i_rx_byte == CH_MINUS) begin
                                    n_neg   = 1'b1;
                                    n_phase = PH_SIGN;
                                end else if (w_digit) begin
                                    n_phase = PH_DIGITS;
                                    if (w_mac > 21'd65535) begin
                                        n_big   = 1'b1;
                                        n_value = NUM_OVER;
                                    end else begin
                                        n_value = w_mac[16:0];
                                    end
                                end else begin
                                    n_phase = PH_FAIL;
                                end
                            end
                        end
                        PH_SIGN, PH_DIGITS: begin
                            if (w_digit) begin
                                n_phase = PH_DIGITS;
                                if (!r_big) begin
                                    if (w_mac > 21'd65535) begin
                                        n_big   = 1'b1;
                                        n_value = NUM_OVER;
                                    end else begin
                                        n_value = w_mac[16:0];
                                    end
                                end
                            end else if ((r_phase == PH_DIGITS) && w_blank) begin
                                n_phase = PH_TRAIL;
                            end else if ((r_phase == PH_DIGITS) && (i_rx_byte == CH_NUL)) begin
                                n_phase = PH_NUM_END;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_TRAIL: begin
                            if (!w_blank) begin
                                n_phase = (i_rx_byte == CH_NUL) ? PH_NUM_END : PH_FAIL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_value <= '0;
            r_big   <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_value <= n_value;
            r_big   <= n_big;
            r_neg   <= n_neg;
        end
    end

endmodule

/* hw/rtl/rtrp_queue.sv */
// ----------------------------------------------------------------------------
// rtrp_queue
// Short record FIFO between the parser and the filter.
// ----------------------------------------------------------------------------
module rtrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtrp_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output rtrp_pkg::t_rec o_rec,
    output logic           o_empty
);

    rtrp_pkg::t_rec r_mem [rtrp_pkg::QUEUE_DEPTH];

    logic [rtrp_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [rtrp_pkg::QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == rtrp_pkg::QCNT_W'(rtrp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/rtrp_back.sv */
// ----------------------------------------------------------------------------
// rtrp_back
// Moving-average filter with serial divider and output register.
// ----------------------------------------------------------------------------
module rtrp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_q_empty,
    input  rtrp_pkg::t_rec               i_q_rec,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_present,
    output logic [rtrp_pkg::DIST_W-1:0]  o_distance_raw,
    output logic [rtrp_pkg::DIST_W-1:0]  o_distance_filtered
);

    localparam int CNT_W  = rtrp_pkg::CNT_W;
    localparam int POS_W  = rtrp_pkg::POS_W;
    localparam int SUM_W  = rtrp_pkg::SUM_W;
    localparam int STEP_W = rtrp_pkg::STEP_W;
    localparam int DIST_W = rtrp_pkg::DIST_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic              r_enable, n_enable;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [DIST_W-1:0] r_d, n_d;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              r_present, n_present;
    logic [DIST_W-1:0] r_raw, n_raw;
    logic [DIST_W-1:0] r_filt, n_filt;

    logic              w_we;
    logic [DIST_W-1:0] w_old;
    logic [SUM_W-1:0]  w_dext;
    logic [CNT_W:0]    w_rem_sh;
    logic              w_ge;

    rtrp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (rtrp_pkg::WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (r_d),
        .i_raddr (r_pos),
        .o_rdata (w_old)
    );

    assign w_dext   = SUM_W'(r_d);
    assign w_rem_sh = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_count});

    always_comb begin
        n_state     = r_state;
        n_enable    = r_enable;
        n_count     = r_count;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_d         = r_d;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_present   = r_present;
        n_raw       = r_raw;
        n_filt      = r_filt;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    if (!i_q_rec.present) begin
                        n_count     = '0;
                        n_pos       = '0;
                        n_sum       = '0;
                        n_present   = 1'b0;
                        n_raw       = '0;
                        n_filt      = '0;
                        n_out_valid = 1'b1;
                    end else if (!r_enable) begin
                        n_present   = 1'b1;
                        n_raw       = i_q_rec.dist_cm;
                        n_filt      = i_q_rec.dist_cm;
                        n_out_valid = 1'b1;
                    end else begin
                        n_d     = i_q_rec.dist_cm;
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                w_we = 1'b1;
                if (r_count < CNT_W'(rtrp_pkg::WINDOW)) begin
                    n_count = r_count + 1'b1;
                    n_sum   = r_sum + w_dext;
                end else begin
                    n_sum = r_sum - SUM_W'(w_old) + w_dext;
                end
                if (r_pos == POS_W'(rtrp_pkg::WINDOW - 1)) begin
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
                n_rem   = '0;
                n_quo   = n_sum;
                n_step  = STEP_W'(SUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = w_ge ? (w_rem_sh - {1'b0, r_count}) : w_rem_sh;
                n_quo  = {r_quo[SUM_W-2:0], w_ge};
                n_step = r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    n_present   = 1'b1;
                    n_raw       = r_d;
                    n_filt      = n_quo[DIST_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we && (i_cfg_wdata != r_enable)) begin
            n_enable = i_cfg_wdata;
            n_count  = '0;
            n_pos    = '0;
            n_sum    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_count     <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enable    <= n_enable;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d       <= n_d;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_present <= n_present;
        r_raw     <= n_raw;
        r_filt    <= n_filt;
    end

    assign o_out_valid         = r_out_valid;
    assign o_present           = r_present;
    assign o_distance_raw      = r_raw;
    assign o_distance_filtered = r_filt;

endmodule

/* hw/rtl/radar_text_record_parser_avg.sv */
// ----------------------------------------------------------------------------
// radar_text_record_parser_avg
// Serial text record parser with a moving-average distance filter.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_ready   i_rx_byte
//   out      output     o_out_valid/i_out_ready o_present, o_distance_raw,
//                                               o_distance_filtered
//   cfg      input      i_cfg_we                i_cfg_wdata
//
// Parser takes one byte per cycle while the queue has room; a line end
// pushes its record into a two-entry queue. Filter: OFF or unfiltered
// records go straight to the output register, averaged ones through the
// bit-serial divider; a record pops only once the last result is taken.
// Reset is synchronous, active low; no clearing pass. o_in_ready drops only
// while the queue is full; a held result blocks the filter, not the parser.
// ----------------------------------------------------------------------------
module radar_text_record_parser_avg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_present,
    output logic [rtrp_pkg::DIST_W-1:0]  o_distance_raw,
    output logic [rtrp_pkg::DIST_W-1:0]  o_distance_filtered,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata
);

    logic           w_push;
    logic           w_pop;
    logic           w_q_full;
    logic           w_q_empty;
    rtrp_pkg::t_rec w_push_rec;
    rtrp_pkg::t_rec w_pop_rec;

    rtrp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_rec     (w_push_rec)
    );

    rtrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec),
        .o_empty (w_q_empty)
    );

    rtrp_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_q_empty           (w_q_empty),
        .i_q_rec             (w_pop_rec),
        .o_q_pop             (w_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_present           (o_present),
        .o_distance_raw      (o_distance_raw),
        .o_distance_filtered (o_distance_filtered)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("record pushed into full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!w_q_empty && !o_out_valid))
        else $error("queue popped while empty or output busy");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> !o_out_valid)
        else $error("result reloaded in the cycle it was taken");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_present) |-> ((o_distance_raw == '0) &&
                                         (o_distance_filtered == '0)))
        else $error("absent record with nonzero distance");

endmodule

/* tb/sv/tb_radar_text_record_parser_avg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radar_text_record_parser_avg
// Self-checking bench for the radar text record parser with averaging.
//
// Byte lines (OFF records, distance records, broken, long, empty and noise
// lines) are queued and driven one beat at a time. An in-bench parser and
// window filter predict each record, and the monitor compares every output
// beat field by field. Three passes vary sender and receiver throttling and
// the filter enable setting.
// ----------------------------------------------------------------------------
module tb_radar_text_record_parser_avg;

    localparam int DIST_W         = rtrp_pkg::DIST_W;
    localparam int SUM_W          = rtrp_pkg::SUM_W;
    localparam int WINDOW         = rtrp_pkg::WINDOW;
    localparam int LINE_MAX_CHARS = rtrp_pkg::LINE_MAX_CHARS;

    localparam int TIMEOUT_NS = 2_000_000;
    localparam int SETTLE     = 4 * (SUM_W + 2);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [3:0] {
        ST_LEAD, ST_O1, ST_O2, ST_OFF, ST_LABEL, ST_SEP, ST_COLON, ST_SIGN,
        ST_DIGITS, ST_TRAIL, ST_FAIL, ST_OFF_END, ST_NUM_END
    } t_parse_st;

    typedef struct packed {
        logic              present;
        logic [DIST_W-1:0] raw;
        logic [DIST_W-1:0] filt;
    } t_record;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_present;
    logic [DIST_W-1:0] o_distance_raw;
    logic [DIST_W-1:0] o_distance_filtered;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_wdata = 1'b0;

    radar_text_record_parser_avg dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_present           (o_present),
        .o_distance_raw      (o_distance_raw),
        .o_distance_filtered (o_distance_filtered),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // stimulus and expectation stores
    logic [7:0]  tx_bytes[$];
    logic [7:0]  line_buf[$];
    t_record     due_records[$];
    int unsigned queued_bytes = 0;
    int unsigned tx_gap_pct   = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned n_mismatch   = 0;

    // predicted parser and filter state
    bit                flt_en;
    t_parse_st         ps;
    int unsigned       ln_len;
    bit                ln_ovf;
    int unsigned       num;
    int unsigned       lbl_idx;
    bit                num_big;
    bit                num_neg;
    logic [DIST_W-1:0] ring [WINDOW];
    int unsigned       ring_wr;
    int unsigned       n_smp;
    int unsigned       smp_sum;
    string             label_txt = "distance";

    task automatic report_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= 50) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    function automatic void clear_filter();
        n_smp   = 0;
        ring_wr = 0;
        smp_sum = 0;
    endfunction

    function automatic void clear_line();
        ps      = ST_LEAD;
        ln_len  = 0;
        ln_ovf  = 1'b0;
        num     = 0;
        lbl_idx = 0;
        num_big = 1'b0;
        num_neg = 1'b0;
    endfunction

    function automatic logic [DIST_W-1:0] filter_add(logic [DIST_W-1:0] d);
        if (n_smp < WINDOW) begin
            n_smp++;
        end else begin
            smp_sum -= ring[ring_wr];
        end
        ring[ring_wr] = d;
        smp_sum += d;
        ring_wr = (ring_wr + 1) % WINDOW;
        return DIST_W'(smp_sum / n_smp);
    endfunction

    function automatic void add_digit(logic [7:0] c);
        if (!num_big) begin
            num = num * 10 + int'(c - CH_ZERO);
            if (num > 65535) begin
                num_big = 1'b1;
                num     = 65536;
            end
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        bit blank;
        bit digit;
        blank = (c == " " || c == CH_TAB);
        digit = (c >= "0" && c <= "9");
        case (ps)
            ST_LEAD: begin
                if (!blank) begin
                    if (c == "O") begin
                        ps = ST_O1;
                    end else if (c == "d") begin
                        lbl_idx = 1;
                        ps = ST_LABEL;
                    end else begin
                        ps = ST_FAIL;
                    end
                end
            end
            ST_O1: ps = (c == "F") ? ST_O2 : ST_FAIL;
            ST_O2: ps = (c == "F") ? ST_OFF : ST_FAIL;
            ST_OFF: ps = (c == CH_NUL) ? ST_OFF_END : ST_FAIL;
            ST_LABEL: begin
                if (c == label_txt[lbl_idx]) begin
                    lbl_idx++;
                    if (lbl_idx >= 8) begin
                        lbl_idx = 0;
                        ps = ST_SEP;
                    end
                end else begin
                    ps = ST_FAIL;
                end
            end
            ST_SEP: begin
                if (!blank) ps = (c == ":") ? ST_COLON : ST_FAIL;
            end
            ST_COLON: begin
                if (!(blank || c == CH_VT || c == CH_FF)) begin
                    if (c == "+") begin
                        ps = ST_SIGN;
                    end else if (c == "-") begin
                        num_neg = 1'b1;
                        ps = ST_SIGN;
                    end else if (digit) begin
                        add_digit(c);
                        ps = ST_DIGITS;
                    end else begin
                        ps = ST_FAIL;
                    end
                end
            end
            ST_SIGN: begin
                if (digit) begin
                    add_digit(c);
                    ps = ST_DIGITS;
                end else begin
                    ps = ST_FAIL;
                end
            end
            ST_DIGITS: begin
                if (digit) add_digit(c);
                else if (blank) ps = ST_TRAIL;
                else if (c == CH_NUL) ps = ST_NUM_END;
                else ps = ST_FAIL;
            end
            ST_TRAIL: begin
                if (!blank) ps = (c == CH_NUL) ? ST_NUM_END : ST_FAIL;
            end
            default: begin
            end
        endcase
    endfunction

    // one accepted byte; a line end may queue one record
    function automatic void parse_rx_byte(logic [7:0] c);
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] f;
        if (c == CH_CR || c == CH_LF) begin
            if (!ln_ovf && ln_len > 0) begin
                if (ps == ST_OFF || ps == ST_OFF_END) begin
                    clear_filter();
                    due_records.push_back('{present: 1'b0, raw: '0, filt: '0});
                end else if ((ps == ST_DIGITS || ps == ST_TRAIL || ps == ST_NUM_END) &&
                             !num_big && !(num_neg && num != 0)) begin
                    d = DIST_W'(num);
                    f = flt_en ? filter_add(d) : d;
                    due_records.push_back('{present: 1'b1, raw: d, filt: f});
                end
            end
            clear_line();
        end else if (!ln_ovf) begin
            if (ln_len < LINE_MAX_CHARS) begin
                ln_len++;
                parse_char(c);
            end else begin
                ln_ovf = 1'b1;
            end
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) parse_rx_byte(i_rx_byte);
            if (!i_in_valid || o_in_ready) begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= tx_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_record r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_records.size() == 0) begin
                report_mismatch($sformatf("unexpected record present=%0b raw=%0d filt=%0d",
                                          o_present, o_distance_raw, o_distance_filtered));
            end else begin
                r = due_records.pop_front();
                if (o_present !== r.present)
                    report_mismatch($sformatf("present got %0b want %0b",
                                              o_present, r.present));
                if (o_distance_raw !== r.raw)
                    report_mismatch($sformatf("distance_raw got %0d want %0d",
                                              o_distance_raw, r.raw));
                if (o_distance_filtered !== r.filt)
                    report_mismatch($sformatf("distance_filtered got %0d want %0d",
                                              o_distance_filtered, r.filt));
            end
        end
    end

    task automatic write_filter_enable(bit v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (v != flt_en) begin
            flt_en = v;
            clear_filter();
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (tx_bytes.size() != 0 || i_in_valid || due_records.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // line building
    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic put_blanks(int n, bit wide);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(wide ? 3 : 1))
                0: line_buf.push_back(" ");
                1: line_buf.push_back(CH_TAB);
                2: line_buf.push_back(CH_VT);
                default: line_buf.push_back(CH_FF);
            endcase
        end
    endtask

    task automatic pad_to(int n);
        while (line_buf.size() < n) line_buf.push_back(" ");
    endtask

    task automatic nul_tail();
        logic [7:0] b;
        line_buf.push_back(CH_NUL);
        repeat ($urandom_range(5)) begin
            b = 8'($urandom_range(255));
            if (b == CH_CR || b == CH_LF) b = CH_NUL;
            line_buf.push_back(b);
        end
    endtask

    task automatic end_line();
        line_buf.push_back($urandom_range(1) ? CH_LF : CH_CR);
        foreach (line_buf[i]) tx_bytes.push_back(line_buf[i]);
        queued_bytes += line_buf.size();
        line_buf.delete();
    endtask

    task automatic line_of(string s);
        put_str(s);
        end_line();
    endtask

    function automatic string number_text();
        int unsigned v;
        string       s;
        case ($urandom_range(11))
            0: v = 0;
            1: v = 65535;
            2: v = 65536 + $urandom_range(1000);
            3: v = $urandom_range(999999);
            default: v = $urandom_range(65535) >> $urandom_range(15);
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(7) == 0) s = {"00", s};
        case ($urandom_range(11))
            0: s = {"+", s};
            1: s = {"-", s};
            2: s = "-00";
            default: begin
            end
        endcase
        return s;
    endfunction

    task automatic distance_body(string n);
        put_blanks($urandom_range(2), 1'b0);
        put_str("distance");
        put_blanks($urandom_range(2), 1'b0);
        put_str(":");
        put_blanks($urandom_range(2), 1'b1);
        put_str(n);
        put_blanks($urandom_range(2), 1'b0);
        if ($urandom_range(7) == 0) nul_tail();
    endtask

    task automatic off_body();
        put_blanks($urandom_range(2), 1'b0);
        put_str("OFF");
        if ($urandom_range(3) == 0) nul_tail();
    endtask

    task automatic random_line();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 66) begin
            distance_body(number_text());
        end else if (k < 74) begin
            off_body();
        end else if (k < 80) begin
            distance_body(number_text());
            pad_to($urandom_range(LINE_MAX_CHARS - 3, LINE_MAX_CHARS + 5));
        end else if (k < 84) begin
            // empty line
        end else if (k < 90) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(1)) distance_body(number_text());
            else off_body();
            if ($urandom_range(1)) begin
                line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
            end else begin
                repeat ($urandom_range(1, 3)) void'(line_buf.pop_back());
            end
        end
        end_line();
    endtask

    task automatic fill_random(int unsigned n);
        int unsigned start;
        start = queued_bytes;
        while (queued_bytes - start < n) random_line();
    endtask

    task automatic run_directed();
        line_of("OFF");
        line_of("distance:0");
        line_of("distance:65535");
        line_of("distance:65536");
        put_str(" \tdistance \t: ");
        line_buf.push_back(CH_VT);
        line_buf.push_back(CH_FF);
        line_of("+12 \t");
        line_of("distance:-0");
        line_of("distance:-000");
        line_of("distance:-5");
        line_of("distance:- 5");
        line_of("distance:");
        line_of("distance:+");
        line_of("distance:99999999");
        line_of("distance:5x");
        line_of("distance:5 x");
        line_of("Distance:5");
        put_str("distance:12");
        line_buf.push_back(CH_NUL);
        line_of("xyz");
        put_str("OFF");
        line_buf.push_back(CH_NUL);
        line_of("\t- !");
        line_of(" \tOFF");
        line_of("OFF ");
        line_of("OF");
        end_line();
        put_str("distance:7");
        line_buf.push_back(CH_CR);
        end_line();
        put_str("distance:1234");
        pad_to(LINE_MAX_CHARS);
        end_line();
        put_str("distance:1234");
        pad_to(LINE_MAX_CHARS + 1);
        end_line();
        repeat (WINDOW + 1) line_of("distance:65535");
        line_of("OFF");
        line_of("distance:10");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h80);
        end_line();
    endtask

    initial begin
        flt_en = 1'b1;
        clear_line();
        clear_filter();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_gap_pct   = 32;
        rx_stall_pct = 76;
        write_filter_enable(1'b1);
        run_directed();
        fill_random(250);
        drain();

        write_filter_enable(1'b0);
        tx_gap_pct   = 76;
        rx_stall_pct = 32;
        fill_random(250);
        drain();

        write_filter_enable(1'b1);
        write_filter_enable(1'b0);
        write_filter_enable(1'b1);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        fill_random(250);
        drain();

        if (n_mismatch == 0) begin
            $display("radar_text_record_parser_avg: match");
        end else begin
            $display("radar_text_record_parser_avg: mismatch");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("radar_text_record_parser_avg: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rtrp_pkg.sv
hw/rtl/rtrp_ram.sv
hw/rtl/rtrp_front.sv
hw/rtl/rtrp_queue.sv
hw/rtl/rtrp_back.sv
hw/rtl/radar_text_record_parser_avg.sv
tb/sv/tb_radar_text_record_parser_avg.sv
